### src/sha512_hash_engine_assert.svh
// assertion macros shared by the checker
`ifndef SHA512_HASH_ENGINE_ASSERT_SVH
`define SHA512_HASH_ENGINE_ASSERT_SVH

// same-cycle implication
`define SHA512_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha512 check failed");

// next-cycle implication
`define SHA512_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha512 check failed");

`endif

### src/sha512_pkg.sv
package sha512_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last;
  } msg_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_t;

  typedef logic [7:0][63:0] hash_t;

  typedef struct packed {
    logic load;
    logic step;
  } round_ctl_t;

  typedef struct packed {
    logic       last_round;
    logic [3:0] rd_addr;
  } round_sts_t;

  localparam logic [6:0]  LAST_ROUND   = 7'd79;
  localparam logic [6:0]  SCHED_WORDS  = 7'd16;
  localparam logic [3:0]  LAST_SLOT    = 4'd15;
  localparam logic [3:0]  FULL_WORD    = 4'd8;
  localparam logic [2:0]  LAST_INDEX   = 3'd7;
  localparam logic [7:0]  LEN_LIMIT    = 8'd112;
  localparam logic [63:0] PAD_MARKER   = 64'h8000_0000_0000_0000;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] x);
    big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] x);
    big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] x);
    small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic hash_t init_hash();
    hash_t h;
    h[0] = 64'h6a09e667f3bcc908;
    h[1] = 64'hbb67ae8584caa73b;
    h[2] = 64'h3c6ef372fe94f82b;
    h[3] = 64'ha54ff53a5f1d36f1;
    h[4] = 64'h510e527fade682d1;
    h[5] = 64'h9b05688c2b3e6c1f;
    h[6] = 64'h1f83d9abfb41bd6b;
    h[7] = 64'h5be0cd19137e2179;
    return h;
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] idx);
    case (idx)
      7'd0:  round_k = 64'h428a2f98d728ae22;
      7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538;
      7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b;
      7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242;
      7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c;
      7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f;
      7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235;
      7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2;
      7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5;
      7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275;
      7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
      7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab;
      7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f;
      7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2;
      7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f;
      7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc;
      7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed;
      7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de;
      7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6;
      7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364;
      7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791;
      7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218;
      7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a;
      7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8;
      7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99;
      7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63;
      7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373;
      7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc;
      7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72;
      7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28;
      7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915;
      7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c;
      7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e;
      7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba;
      7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae;
      7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84;
      7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc;
      7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6;
      7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec;
      7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = 64'h0;
    endcase
  endfunction

endpackage

### src/sha512_stream_if.sv
interface sha512_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/sha512_round.sv
module sha512_round import sha512_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  round_ctl_t ctl,
  input  hash_t      h,
  input  logic [63:0] rdata,
  output hash_t      vars,
  output round_sts_t sts
);

  logic [6:0]  rnd;
  logic [63:0] win [16];
  logic [63:0] w_cur;
  logic [63:0] t1;
  logic [63:0] t2;
  logic [63:0] ch;
  logic [63:0] maj;

  // first sixteen rounds take the block straight from the buffer read port
  always_comb begin
    if (rnd < SCHED_WORDS) begin
      w_cur = rdata;
    end else begin
      w_cur = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
    end
    ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1  = vars[7] + big_sigma1(vars[4]) + ch + round_k(rnd) + w_cur;
    t2  = big_sigma0(vars[0]) + maj;
  end

  assign sts.last_round = (rnd == LAST_ROUND);
  assign sts.rd_addr    = rnd[3:0] + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd  <= '0;
      vars <= '0;
    end else if (ctl.load) begin
      rnd  <= '0;
      vars <= h;
    end else if (ctl.step) begin
      rnd     <= rnd + 7'd1;
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  // schedule window, newest word at the top
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_cur;
    end
  end

endmodule

### src/sha512_hash_engine.sv
// Streaming SHA-512 hasher. Message words are written into a 16-entry block buffer
// memory, one word per accepted request; a word that is not last always counts as
// eight bytes. When the sixteenth word lands, the block is compressed: a load
// step, 80 rounds at one round per clock (the schedule is read from the buffer
// memory for the first 16 rounds and then kept in a sliding window), and a fold
// of the result into the chaining value; no request is taken meanwhile. A last
// word is masked to its byte count, followed by padding written one buffer entry
// per cycle (to the end of the block, and a whole extra block when the length
// does not fit), one or two compressions, and then eight digest words, word 0
// first, one per cycle while the consumer is ready. The next message may start
// as soon as the last digest word sits in the output register.
module sha512_hash_engine import sha512_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  sha512_stream_if.sink   msg,
  sha512_stream_if.source digest
);

  state_t      state;
  state_t      state_next;
  hash_t       hash;
  hash_t       vars;
  logic [63:0] byte_total;
  logic [3:0]  ptr;
  logic        marker;
  logic        final_blk;
  logic        padding;
  logic [2:0]  out_idx;
  logic        out_valid;
  dig_t        out_data;

  logic [63:0] mem [16];
  logic [63:0] rdata;

  logic        in_ready;
  logic        acc;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [63:0] wr_data;
  logic [3:0]  rd_addr;
  logic        fold_en;
  logic        out_load;
  round_ctl_t  rctl;
  round_sts_t  rsts;

  logic [3:0]  wslot;
  logic [3:0]  n_clamp;
  logic [5:0]  shamt;
  logic [63:0] last_data;
  logic [7:0]  pad_pos;
  logic        room;
  logic [63:0] length;

  assign acc   = msg.valid && in_ready;
  assign wslot = byte_total[6:3];

  // last word: keep leading bytes, drop in the 0x80 marker unless the word is full
  always_comb begin
    n_clamp   = (msg.data.byte_count > FULL_WORD) ? FULL_WORD : msg.data.byte_count;
    shamt     = {n_clamp[2:0], 3'b000};
    last_data = (msg.data.message_word & ~({64{1'b1}} >> shamt)) | (PAD_MARKER >> shamt);
    if (n_clamp[3]) begin
      last_data = msg.data.message_word;
    end
    pad_pos = {1'b0, wslot, 3'b000} + {4'b0000, n_clamp};
    room    = (pad_pos < LEN_LIMIT);
    length  = {byte_total[60:0], 3'b000};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (wslot == LAST_SLOT) begin
            state_next = ST_LOAD;
          end else if (msg.data.last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (ptr == LAST_SLOT) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (rsts.last_round) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!padding) begin
          state_next = ST_IDLE;
        end else if (final_blk) begin
          state_next = ST_OUTPUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_OUTPUT: begin
        if (out_load && out_idx == LAST_INDEX) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = ptr;
    wr_data   = '0;
    rd_addr   = '0;
    fold_en   = 1'b0;
    out_load  = 1'b0;
    rctl      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        wr_en    = acc;
        wr_addr  = wslot;
        wr_data  = msg.data.last ? last_data : msg.data.message_word;
      end
      ST_PAD: begin
        wr_en = 1'b1;
        if (marker) begin
          wr_data = PAD_MARKER;
        end else if (ptr == LAST_SLOT && final_blk) begin
          wr_data = length;
        end
      end
      ST_LOAD:  rctl.load = 1'b1;
      ST_ROUND: begin
        rctl.step = 1'b1;
        rd_addr   = rsts.rd_addr;
      end
      ST_FOLD:   fold_en = 1'b1;
      ST_OUTPUT: out_load = !out_valid || digest.ready;
      default: ;
    endcase
  end

  // block buffer; writes and round reads never overlap in time
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  sha512_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rctl),
    .h     (hash),
    .rdata (rdata),
    .vars  (vars),
    .sts   (rsts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hash       <= init_hash();
      byte_total <= '0;
      ptr        <= '0;
      marker     <= 1'b0;
      final_blk  <= 1'b0;
      padding    <= 1'b0;
      out_idx    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        byte_total <= byte_total + (msg.data.last ? {60'd0, n_clamp} : 64'd8);
        if (msg.data.last) begin
          padding <= 1'b1;
          marker  <= n_clamp[3];
          if (wslot == LAST_SLOT) begin
            final_blk <= 1'b0;
          end else begin
            ptr       <= wslot + 4'd1;
            final_blk <= room;
          end
        end
      end
      if (state == ST_PAD) begin
        ptr    <= ptr + 4'd1;
        marker <= 1'b0;
      end
      if (fold_en) begin
        for (int j = 0; j < 8; j++) begin
          hash[j] <= hash[j] + vars[j];
        end
        // length did not fit: one more block of padding, ending in the length
        if (padding && !final_blk) begin
          ptr       <= '0;
          final_blk <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
        out_idx   <= out_idx + 3'd1;
        if (out_idx == LAST_INDEX) begin
          hash       <= init_hash();
          byte_total <= '0;
          padding    <= 1'b0;
        end
      end else if (digest.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.digest_word <= hash[out_idx];
      out_data.word_index  <= out_idx;
      out_data.last_word   <= (out_idx == LAST_INDEX);
    end
  end

  assign msg.ready    = in_ready;
  assign digest.valid = out_valid;
  assign digest.data  = out_data;

endmodule

### src/sha512_checker.sv
`include "sha512_hash_engine_assert.svh"

module sha512_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] word_index,
  input logic       last_word
);

  `SHA512_ASSERT_IMP(a_last_flag, clk, rst, out_valid, last_word == (word_index == 3'd7))
  `SHA512_ASSERT_NEXT(a_busy_after_last, clk, rst, in_valid && in_ready && in_last, !in_ready)
  `SHA512_ASSERT_IMP(a_first_word, clk, rst, $rose(out_valid), word_index == 3'd0)
  `SHA512_ASSERT_NEXT(a_index_step, clk, rst, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1)

endmodule

bind sha512_hash_engine sha512_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (msg.valid),
  .in_ready   (msg.ready),
  .in_last    (msg.data.last),
  .out_valid  (digest.valid),
  .out_ready  (digest.ready),
  .word_index (digest.data.word_index),
  .last_word  (digest.data.last_word)
);
